[sv/crc32c_pkg.sv]
// Shared constants, types and elaboration-time matrix builders for the CRC-32C stream block.
package crc32c_pkg;

	localparam int unsigned DATA_W              = 64;
	localparam int unsigned CRC_W               = 32;
	localparam int unsigned COUNT_W             = 4;
	localparam int unsigned VEC_W               = DATA_W + CRC_W;
	localparam int unsigned DATA_BYTES          = DATA_W / 8;
	localparam int unsigned BYTES_PER_CHUNK_DEF = 8;

	localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'h82F6_3B78;
	localparam logic [CRC_W-1:0] CRC_INVERT    = 32'hFFFF_FFFF;

	// One row per remainder bit, one column per bit of {data, remainder}.
	typedef logic [CRC_W-1:0][VEC_W-1:0] fold_mat_t;

	// Bit-serial reference fold, evaluated only at elaboration to build the matrices.
	function automatic logic [CRC_W-1:0] fold_serial(input logic [CRC_W-1:0] r_in,
		input logic [DATA_W-1:0] data, input int unsigned nbytes);
		logic [CRC_W-1:0] r;
		logic [7:0] b;
		r = r_in;
		for (int unsigned k = 0; k < nbytes; k++) begin
			b = '0;
			if (k < DATA_BYTES) begin
				b = data[8*k +: 8];
			end
			r = r ^ {{(CRC_W-8){1'b0}}, b};
			for (int unsigned i = 0; i < 8; i++) begin
				if (r[0]) begin
					r = (r >> 1) ^ CRC_POLY_REFL;
				end else begin
					r = r >> 1;
				end
			end
		end
		return r;
	endfunction

	// GF(2) matrix of folding nbytes bytes: image of each unit vector of {data, remainder}.
	function automatic fold_mat_t build_fold_mat(input int unsigned nbytes);
		fold_mat_t m;
		logic [VEC_W-1:0] u;
		logic [CRC_W-1:0] img;
		m = '0;
		for (int unsigned j = 0; j < VEC_W; j++) begin
			u = '0;
			u[j] = 1'b1;
			img = fold_serial(u[CRC_W-1:0], u[VEC_W-1:CRC_W], nbytes);
			for (int unsigned i = 0; i < CRC_W; i++) begin
				m[i][j] = img[i];
			end
		end
		return m;
	endfunction

endpackage

[sv/crc32c_in_if.sv]
// Chunk channel: valid/ready handshake carrying one message chunk.
interface crc32c_in_if;
	logic                               valid;
	logic                               ready;
	logic [crc32c_pkg::DATA_W-1:0]      chunk_data;
	logic [crc32c_pkg::COUNT_W-1:0]     byte_count;
	logic                               first_chunk;
	logic [crc32c_pkg::CRC_W-1:0]       seed_value;
	logic                               last_chunk;

	modport source (output valid, chunk_data, byte_count, first_chunk, seed_value, last_chunk,
		input ready);
	modport sink (input valid, chunk_data, byte_count, first_chunk, seed_value, last_chunk,
		output ready);
endinterface

[sv/crc32c_out_if.sv]
// Result channel: valid/ready handshake carrying one finished CRC.
interface crc32c_out_if;
	logic                          valid;
	logic                          ready;
	logic [crc32c_pkg::CRC_W-1:0]  crc_value;

	modport source (output valid, crc_value, input ready);
	modport sink (input valid, crc_value, output ready);
endinterface

[sv/crc32c_fold.sv]
// Parallel GF(2) remainder update over the valid bytes of one chunk.
module crc32c_fold #(
	parameter int unsigned BYTES_PER_CHUNK = crc32c_pkg::BYTES_PER_CHUNK_DEF
) (
	input  logic [crc32c_pkg::CRC_W-1:0]   rem_in,
	input  logic [crc32c_pkg::DATA_W-1:0]  data,
	input  logic [crc32c_pkg::COUNT_W-1:0] byte_count,
	output logic [crc32c_pkg::CRC_W-1:0]   rem_out
);

	localparam int unsigned CNT_W = $clog2(BYTES_PER_CHUNK + 1);

	logic [crc32c_pkg::VEC_W-1:0]                    vec;
	logic [BYTES_PER_CHUNK:0][crc32c_pkg::CRC_W-1:0] img;
	logic [CNT_W-1:0]                                cnt_sat;

	assign vec = {data, rem_in};

	// Clamp the count to the chunk size.
	always_comb begin
		if (32'(byte_count) > 32'(BYTES_PER_CHUNK)) begin
			cnt_sat = CNT_W'(BYTES_PER_CHUNK);
		end else begin
			cnt_sat = CNT_W'(byte_count);
		end
	end

	// One XOR matrix per possible byte count; each output bit is a parity of masked inputs.
	for (genvar n = 0; n <= BYTES_PER_CHUNK; n++) begin : g_cnt
		localparam crc32c_pkg::fold_mat_t MAT = crc32c_pkg::build_fold_mat(n);
		for (genvar i = 0; i < crc32c_pkg::CRC_W; i++) begin : g_bit
			assign img[n][i] = ^(MAT[i] & vec);
		end
	end

	assign rem_out = img[cnt_sat];

endmodule

[sv/crc32c_stream.sv]
// Top level of the streaming CRC-32C engine: input register, fold, remainder and result register.
//
// Streaming CRC-32C (Castagnoli, reflected, polynomial 0x82F63B78). Chunks of one to
// BYTES_PER_CHUNK bytes arrive on the chunk channel, first byte in bits 7..0; byte
// counts above the chunk size are clamped and a count of zero folds nothing. A chunk
// with first_chunk set restarts the remainder from the inverted seed_value; any other
// chunk continues from the running remainder, which resets to all ones and is kept
// after a last chunk, so messages chain. A chunk with last_chunk set yields one
// transfer on the result channel carrying the inverted remainder. Throughput is one
// chunk per clock while the input register does not stall: the remainder register
// feeds back through a single parallel XOR matrix per byte count, so each chunk's
// fold is registered into the remainder as the chunk leaves the input register.
// Result valid is set as a last chunk leaves the input register; the chunk passes
// the input register, then the result register. The input register stalls only when
// it holds a last chunk and the result register is occupied and not being taken.
module crc32c_stream #(
	parameter int unsigned BYTES_PER_CHUNK = crc32c_pkg::BYTES_PER_CHUNK_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	crc32c_in_if.sink    chunk,
	crc32c_out_if.source result
);

	// Input stage
	logic                             valid_s1;
	logic [crc32c_pkg::DATA_W-1:0]    data_s1;
	logic [crc32c_pkg::COUNT_W-1:0]   count_s1;
	logic                             first_s1;
	logic [crc32c_pkg::CRC_W-1:0]     seed_s1;
	logic                             last_s1;

	// Running remainder and result register
	logic [crc32c_pkg::CRC_W-1:0]     rem_q;
	logic                             out_valid_q;
	logic [crc32c_pkg::CRC_W-1:0]     out_crc_q;

	logic                             out_free;
	logic                             s1_go;
	logic                             s1_fire;
	logic [crc32c_pkg::CRC_W-1:0]     rem_start;
	logic [crc32c_pkg::CRC_W-1:0]     rem_next;

	// The result slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || result.ready;
	// A chunk that produces no result never waits on the result side.
	assign s1_go    = !last_s1 || out_free;
	assign s1_fire  = valid_s1 && s1_go;

	// Accept a new chunk whenever the input stage is empty or moving on.
	assign chunk.ready = !valid_s1 || s1_go;

	// Restart from the inverted seed on a first chunk, otherwise continue.
	assign rem_start = first_s1 ? (seed_s1 ^ crc32c_pkg::CRC_INVERT) : rem_q;

	crc32c_fold #(
		.BYTES_PER_CHUNK(BYTES_PER_CHUNK)
	) u_fold (
		.rem_in     (rem_start),
		.data       (data_s1),
		.byte_count (count_s1),
		.rem_out    (rem_next)
	);

	// Input stage control: load on transfer, drop once folded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chunk.ready) begin
			valid_s1 <= chunk.valid;
		end
	end

	// Input stage payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (chunk.valid && chunk.ready) begin
			data_s1  <= chunk.chunk_data;
			count_s1 <= chunk.byte_count;
			first_s1 <= chunk.first_chunk;
			seed_s1  <= chunk.seed_value;
			last_s1  <= chunk.last_chunk;
		end
	end

	// Advance the remainder by one chunk per fold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= crc32c_pkg::CRC_INVERT;
		end else if (s1_fire) begin
			rem_q <= rem_next;
		end
	end

	// Result register: load on a folded last chunk, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			out_crc_q <= rem_next ^ crc32c_pkg::CRC_INVERT;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.crc_value = out_crc_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the streaming CRC-32C engine: driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;

	// Chunk size of the block under test. Keep it at the package default.
	localparam int unsigned CHUNK_BYTES = crc32c_pkg::BYTES_PER_CHUNK_DEF;
	// Number of random chunks after the directed part.
	localparam int unsigned RANDOM_CHUNKS = 1700;
	// Cycles without any transfer before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 2000;
	// Cycles to keep running after the last expected CRC has come out.
	localparam int unsigned DRAIN_CYCLES = 8;
	// Long receiver hold-off: length and the chunk count that triggers it.
	localparam int unsigned HOLD_CYCLES = 120;
	localparam int unsigned HOLD_AFTER = 600;
	localparam int unsigned MAX_REPORTS = 10;

	typedef logic [crc32c_pkg::COUNT_W-1:0] count_t;

	typedef struct {
		logic [crc32c_pkg::DATA_W-1:0]  data;
		logic [crc32c_pkg::COUNT_W-1:0] count;
		logic                           first;
		logic [crc32c_pkg::CRC_W-1:0]   seed;
		logic                           last;
	} chunk_item_t;

	logic clk;
	logic arst_n;

	crc32c_in_if  chunk ();
	crc32c_out_if result ();

	crc32c_stream #(
		.BYTES_PER_CHUNK(CHUNK_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chunk  (chunk),
		.result (result)
	);

	// Chunks waiting to be offered, and CRCs waiting to come out, oldest first.
	chunk_item_t                  chunk_pending[$];
	logic [crc32c_pkg::CRC_W-1:0] crc_expected[$];

	// Running remainder of the predictor; all ones out of reset.
	logic [crc32c_pkg::CRC_W-1:0] crc_remainder;

	int unsigned chunk_total;
	int unsigned chunk_issued;
	int unsigned chunk_accepted;
	int unsigned mismatch_cnt;

	// Fold the valid bytes of one chunk into a remainder, LSB first.
	// Counts above the chunk size saturate; a count of zero folds nothing.
	function automatic logic [crc32c_pkg::CRC_W-1:0] crc_fold_chunk(
		input logic [crc32c_pkg::CRC_W-1:0] rem,
		input logic [crc32c_pkg::DATA_W-1:0] data, input logic [crc32c_pkg::COUNT_W-1:0] count);
		int unsigned nbytes;
		int unsigned k;
		int unsigned b;
		logic [crc32c_pkg::CRC_W-1:0] r;
		logic [7:0] byte_val;
		nbytes = (count > CHUNK_BYTES) ? CHUNK_BYTES : count;
		r = rem;
		for (k = 0; k < nbytes; k++) begin
			byte_val = (k < crc32c_pkg::DATA_BYTES) ? data[8*k +: 8] : 8'h00;
			r = r ^ {{(crc32c_pkg::CRC_W-8){1'b0}}, byte_val};
			for (b = 0; b < 8; b++) begin
				r = r[0] ? ((r >> 1) ^ crc32c_pkg::CRC_POLY_REFL) : (r >> 1);
			end
		end
		return r;
	endfunction

	// Mix of dense random data with all-zero and all-one words.
	function automatic logic [crc32c_pkg::DATA_W-1:0] random_chunk_data();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	task automatic queue_chunk(input logic [crc32c_pkg::DATA_W-1:0] data,
		input logic [crc32c_pkg::COUNT_W-1:0] count,
		input logic first, input logic [crc32c_pkg::CRC_W-1:0] seed, input logic last);
		chunk_item_t it;
		it.data  = data;
		it.count = count;
		it.first = first;
		it.seed  = seed;
		it.last  = last;
		chunk_pending.push_back(it);
	endtask

	// Clock: 10 ns period.
	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Input monitor: on every chunk transfer advance the predictor and queue the CRC
	// that a last chunk must produce. Sample at the rising edge, before the block
	// updates its own state.
	always @(posedge clk) begin : chunk_monitor
		if (arst_n && chunk.valid && chunk.ready) begin
			if (chunk.first_chunk) begin
				crc_remainder = chunk.seed_value ^ crc32c_pkg::CRC_INVERT;
			end
			crc_remainder = crc_fold_chunk(crc_remainder, chunk.chunk_data, chunk.byte_count);
			if (chunk.last_chunk) begin
				crc_expected.push_back(crc_remainder ^ crc32c_pkg::CRC_INVERT);
			end
			chunk_accepted++;
		end
	end

	// Output monitor: compare every result transfer against the oldest expected CRC.
	always @(posedge clk) begin : crc_monitor
		logic [crc32c_pkg::CRC_W-1:0] want;
		logic                         have_want;
		if (arst_n && result.valid && result.ready) begin
			have_want = (crc_expected.size() != 0);
			want = have_want ? crc_expected.pop_front() : '0;
			if (!have_want || result.crc_value !== want) begin
				if (mismatch_cnt < MAX_REPORTS) begin
					if (have_want) begin
						$display("%0t: crc_value mismatch: expected %08h, actual %08h",
							$realtime, want, result.crc_value);
					end else begin
						$display("%0t: unexpected result, crc_value %08h",
							$realtime, result.crc_value);
					end
				end
				mismatch_cnt++;
			end
		end
	end

	// Chunk driver: change inputs at the falling edge. Hold a chunk until it is
	// taken, then either open a gap or offer the next one. Bursts and gaps have
	// random length; an occasional long burst gives stretches with no idling.
	always @(negedge clk) begin : chunk_driver
		chunk_item_t it;
		static logic        busy = 1'b0;
		static int unsigned burst_left = 0;
		static int unsigned gap_left = 0;
		if (arst_n) begin
			if (busy && chunk_accepted == chunk_issued) begin
				busy = 1'b0;
			end
			if (!busy) begin
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
						: $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
				end
				if (gap_left == 0 && chunk_pending.size() != 0) begin
					it = chunk_pending.pop_front();
					chunk.chunk_data  <= it.data;
					chunk.byte_count  <= it.count;
					chunk.first_chunk <= it.first;
					chunk.seed_value  <= it.seed;
					chunk.last_chunk  <= it.last;
					chunk.valid       <= 1'b1;
					chunk_issued++;
					burst_left--;
					busy = 1'b1;
				end else begin
					// Idle: drop valid and scramble the payload, which must be ignored.
					if (gap_left != 0) begin
						gap_left--;
					end
					chunk.chunk_data  <= {$urandom, $urandom};
					chunk.byte_count  <= count_t'($urandom_range(0, 15));
					chunk.first_chunk <= 1'($urandom_range(0, 1));
					chunk.seed_value  <= $urandom;
					chunk.last_chunk  <= 1'($urandom_range(0, 1));
					chunk.valid       <= 1'b0;
				end
			end
		end
	end

	// Result receiver: change ready at the falling edge. Switch stall mode at random
	// between always ready, coin toss, a rotating pattern and a mostly stalled
	// mode. Once, hold ready low for a long stretch while the driver keeps offering,
	// so the block backs up and stalls its input.
	always @(negedge clk) begin : crc_receiver
		static int unsigned cycle_cnt = 0;
		static int unsigned stall_mode = 0;
		static int unsigned hold_left = 0;
		static logic        hold_done = 1'b0;
		static logic [7:0]  ready_pat = 8'b1011_0010;
		if (arst_n) begin
			cycle_cnt++;
			if (cycle_cnt % 50 == 0) begin
				stall_mode = $urandom_range(0, 3);
				ready_pat  = 8'($urandom);
			end
			ready_pat = {ready_pat[6:0], ready_pat[7]};
			if (!hold_done && chunk_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: begin
						result.ready <= 1'b1;
					end
					1: begin
						result.ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						result.ready <= ready_pat[0];
					end
					default: begin
						result.ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin : watchdog
		static int unsigned quiet_cycles = 0;
		if (arst_n) begin
			if ((chunk.valid && chunk.ready) || (result.valid && result.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : sequencer
		int unsigned n;
		int unsigned j;
		int unsigned msg_len;
		logic [crc32c_pkg::COUNT_W-1:0] cnt;

		// Drive every input to a known value before the first edge.
		arst_n            = 1'b0;
		chunk.valid       = 1'b0;
		chunk.chunk_data  = '0;
		chunk.byte_count  = '0;
		chunk.first_chunk = 1'b0;
		chunk.seed_value  = '0;
		chunk.last_chunk  = 1'b0;
		result.ready      = 1'b0;
		crc_remainder     = crc32c_pkg::CRC_INVERT;
		chunk_issued      = 0;
		chunk_accepted    = 0;
		mismatch_cnt      = 0;

		// Directed part.
		// Continue from the reset remainder without a first chunk, then finish.
		queue_chunk(64'h0123_4567_89AB_CDEF, 4'd4, 1'b0, 32'h0, 1'b0);
		queue_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 32'h0, 1'b1);
		// Chain straight on after a last chunk.
		queue_chunk(64'h0000_0000_00A5_5AC3, 4'd3, 1'b0, 32'h0, 1'b1);
		// Check string "123456789" from a zero seed.
		queue_chunk(64'h3837_3635_3433_3231, 4'd8, 1'b1, 32'h0, 1'b0);
		queue_chunk(64'h0000_0000_0000_0039, 4'd1, 1'b0, 32'hFFFF_FFFF, 1'b1);
		// First and last in one chunk, extreme seeds and data.
		queue_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b1);
		queue_chunk(64'h0000_0000_0000_0000, 4'd8, 1'b1, 32'h0000_0000, 1'b1);
		queue_chunk(64'h0000_0000_0000_0000, 4'd1, 1'b1, 32'h0000_0000, 1'b1);
		// Zero byte count: seed passes straight through; also mid-message.
		queue_chunk(64'hDEAD_BEEF_CAFE_F00D, 4'd0, 1'b1, 32'h1234_5678, 1'b1);
		queue_chunk(64'h1122_3344_5566_7788, 4'd5, 1'b1, 32'h8765_4321, 1'b0);
		queue_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 32'hFFFF_FFFF, 1'b0);
		queue_chunk(64'h99AA_BBCC_DDEE_FF00, 4'd2, 1'b0, 32'h0, 1'b1);
		// Counts above the chunk size saturate.
		queue_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1, 32'h0, 1'b1);
		queue_chunk(64'hA5A5_5A5A_0F0F_F0F0, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1);
		// Every count from one to eight in one message.
		for (j = 1; j <= CHUNK_BYTES; j++) begin
			queue_chunk({$urandom, $urandom}, j[crc32c_pkg::COUNT_W-1:0], (j == 1), $urandom,
				(j == CHUNK_BYTES));
		end

		// Random part: mostly well-formed messages, some chained without a first
		// chunk, the rest loose chunks with random flags.
		n = 0;
		while (n < RANDOM_CHUNKS) begin
			if ($urandom_range(0, 9) < 8) begin
				msg_len = $urandom_range(1, 6);
				for (j = 0; j < msg_len; j++) begin
					cnt = ($urandom_range(0, 9) == 0) ? count_t'($urandom_range(0, 15))
						: count_t'($urandom_range(1, CHUNK_BYTES));
					queue_chunk(random_chunk_data(), cnt,
						(j == 0) && ($urandom_range(0, 7) != 0), $urandom,
						(j == msg_len - 1));
				end
				n += msg_len;
			end else begin
				queue_chunk(random_chunk_data(), count_t'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
				n++;
			end
		end
		chunk_total = chunk_pending.size();

		// Reset once; release at a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every chunk to be taken and every CRC to come out, then drain.
		while (chunk_accepted != chunk_total) begin
			@(posedge clk);
		end
		while (crc_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && crc_expected.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
